>>> hdl/ipd_frame_payload_extractor_defines.svh
// Assertion macros shared by the frame payload extractor RTL.
`ifndef IPD_FRAME_PAYLOAD_EXTRACTOR_DEFINES_SVH
`define IPD_FRAME_PAYLOAD_EXTRACTOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset.
`define IPD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ipd assertion failed");
// Next-cycle implication, disabled while in reset.
`define IPD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ipd assertion failed");
`else
`define IPD_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define IPD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> hdl/ipd_pkg.sv
// Constants and types for the frame payload extractor.
package ipd_pkg;

    localparam int LENGTH_BITS_DEF = 20;

    localparam int IN_W  = 8;
    localparam int OUT_W = 16;
    localparam int CH_W  = 6;

    // Header characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_I     = 8'h49;  // 'I'
    localparam logic [7:0] CH_P     = 8'h50;  // 'P'
    localparam logic [7:0] CH_D     = 8'h44;  // 'D'
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    // Header match positions
    localparam logic [2:0] HP_IDLE  = 3'd0;
    localparam logic [2:0] HP_PLUS  = 3'd1;
    localparam logic [2:0] HP_I     = 3'd2;
    localparam logic [2:0] HP_P     = 3'd3;
    localparam logic [2:0] HP_D     = 3'd4;
    localparam logic [2:0] HP_COMMA = 3'd5;
    localparam logic [2:0] HP_CHAN  = 3'd6;

    // Length digit positions
    localparam logic [2:0] DP_LAST_COUNTED = 3'd5;
    localparam logic [2:0] DP_MAX          = 3'd6;

    typedef struct packed {
        logic [CH_W-1:0] channel_char;
        logic            channel_valid;
        logic [7:0]      payload_byte;
        logic            payload_valid;
    } ipd_result_t;

endpackage

>>> hdl/ipd_frame_payload_extractor.sv
// Top level of the "+IPD,<ch>,<len>:" receive parser and payload extractor.
//
// Channel   Ports            Transfer contents (lowest bit first)
// --------  ---------------  ------------------------------------------------------
// input     s_axis_*         tdata[7:0] rx_byte
// result    m_axis_*         tdata[0] payload_valid, [8:1] payload_byte,
//                            [9] channel_valid, [15:10] channel_char
//
// One result per input byte, registered: the parser state and the
// result register update together at the edge that takes the byte.
// Sustained rate is one byte per clock while m_axis is not stalled; the result register is the only stage.
// A new byte is taken whenever the result register is empty or drains in the
// same cycle, so a stalled m_axis side holds s_axis_tready low.
// aresetn is synchronous and active low; it clears the parser state and
// the result valid flag.
`include "ipd_frame_payload_extractor_defines.svh"

module ipd_frame_payload_extractor #(
    parameter int LENGTH_BITS = ipd_pkg::LENGTH_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [ipd_pkg::IN_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [0] payload_valid, [8:1] payload_byte, [9] channel_valid, [15:10] channel_char
    output logic [ipd_pkg::OUT_W-1:0] m_axis_tdata
);
    import ipd_pkg::*;

    localparam int WIDE_W = LENGTH_BITS + 4;

    // Parser state
    logic                   pa_reg,  pa_next;   // payload pass-through active
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;  // bytes left / length gathered
    logic                   lp_reg,  lp_next;   // length digits being gathered
    logic [2:0]             dp_reg,  dp_next;   // length positions seen
    logic [2:0]             hp_reg,  hp_next;   // header chars matched

    // Result register
    logic        out_valid_reg, out_valid_next;
    ipd_result_t res_reg, res_next;

    logic              accept;
    logic [7:0]        c;
    logic              is_digit;
    logic [WIDE_W-1:0] len_wide;
    logic [WIDE_W-1:0] rem_wide;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = res_reg;

    assign c        = s_axis_tdata;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

    always_comb begin
        pa_next  = pa_reg;
        rem_next = rem_reg;
        lp_next  = lp_reg;
        dp_next  = dp_reg;
        hp_next  = hp_reg;
        res_next = '0;
        rem_wide = '0;
        len_wide = '0;

        // Payload stage: pass a byte while the count lasts, end on the byte after.
        if (pa_reg) begin
            if (rem_reg != '0) begin
                rem_next               = rem_reg - LENGTH_BITS'(1);
                res_next.payload_valid = 1'b1;
                res_next.payload_byte  = c;
            end else begin
                pa_next  = 1'b0;
                rem_next = '0;
                lp_next  = 1'b0;
            end
        end

        // Length stage: sees the state left by the payload stage.
        if (lp_next) begin
            if (dp_next <= DP_LAST_COUNTED) begin
                dp_next = dp_next + 3'd1;
                if (c == CH_COLON) begin
                    lp_next = 1'b0;
                    dp_next = '0;
                    pa_next = 1'b1;
                end else if (is_digit) begin
                    // length * 10 + digit, saturating at all ones
                    rem_wide = {4'b0, rem_next};
                    len_wide = (rem_wide << 3) + (rem_wide << 1)
                             + {{(WIDE_W-4){1'b0}}, 4'(c - CH_ZERO)};
                    if (|len_wide[WIDE_W-1:LENGTH_BITS]) begin
                        rem_next = '1;
                    end else begin
                        rem_next = len_wide[LENGTH_BITS-1:0];
                    end
                end
            end else begin
                // Wrap the position; the phase stays open.
                dp_next = '0;
            end
        end

        // Header matcher: runs on every byte, payload included.
        if (c == CH_PLUS && hp_reg == HP_IDLE) begin
            hp_next = HP_PLUS;
        end else if (c == CH_I && hp_reg == HP_PLUS) begin
            hp_next = HP_I;
        end else if (c == CH_P && hp_reg == HP_I) begin
            hp_next = HP_P;
        end else if (c == CH_D && hp_reg == HP_P) begin
            hp_next = HP_D;
        end else if (c == CH_COMMA && hp_reg == HP_D) begin
            hp_next = HP_COMMA;
        end else if (is_digit && hp_reg == HP_COMMA) begin
            hp_next                = HP_CHAN;
            res_next.channel_valid = 1'b1;
            res_next.channel_char  = c[CH_W-1:0];
        end else if (c == CH_COMMA && hp_reg == HP_CHAN) begin
            hp_next  = HP_IDLE;
            lp_next  = 1'b1;
            dp_next  = '0;
            rem_next = '0;
        end else if (c == CH_PLUS && hp_reg == HP_PLUS) begin
            hp_next = HP_PLUS;
        end else begin
            // Any other byte, a late '+' included, drops the match.
            hp_next = HP_IDLE;
        end
    end

    always_comb begin
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pa_reg        <= 1'b0;
            rem_reg       <= '0;
            lp_reg        <= 1'b0;
            dp_reg        <= '0;
            hp_reg        <= HP_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                pa_reg  <= pa_next;
                rem_reg <= rem_next;
                lp_reg  <= lp_next;
                dp_reg  <= dp_next;
                hp_reg  <= hp_next;
            end
        end
    end

    // Result payload holds until the next accepted byte.
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    // Position counters never pass their last legal value.
    `IPD_ASSERT_IMPL(a_pos_range, aclk, aresetn, 1'b1, dp_reg <= DP_MAX && hp_reg <= HP_CHAN)
    // A byte taken while a nonzero count is active comes out as payload.
    `IPD_ASSERT_NEXT(a_payload_pass, aclk, aresetn, accept && pa_reg && rem_reg != '0, m_axis_tvalid && m_axis_tdata[0])
    // A digit after "+IPD," is reported as the channel.
    `IPD_ASSERT_NEXT(a_channel_seen, aclk, aresetn, accept && hp_reg == HP_COMMA && is_digit, m_axis_tvalid && m_axis_tdata[9])
    // A non-payload result carries a zero byte.
    `IPD_ASSERT_IMPL(a_idle_byte_zero, aclk, aresetn, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[8:1] == 8'd0)

endmodule

>>> verif/tb_ipd_frame_payload_extractor.sv
// Self-checking testbench for the +IPD frame parser and payload extractor.
`timescale 1ns / 100ps

module tb_ipd_frame_payload_extractor;
    import ipd_pkg::*;

    localparam int          LEN_W       = LENGTH_BITS_DEF;
    localparam logic [63:0] LEN_CEIL    = (64'd1 << LEN_W) - 64'd1;
    localparam int          DIR_N       = 20;
    localparam int          RAND_ITEMS  = 650;
    localparam int          CYCLE_LIMIT = 200000;
    localparam ipd_result_t QUIET       = '0;

    // One directed row: the byte to send and, where pinned, its expected result.
    typedef struct {
        logic [7:0]  b;
        bit          pinned;
        ipd_result_t res;
    } stim_row_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata  = '0;    // [7:0] rx_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [0] payload_valid, [8:1] payload_byte, [9] channel_valid, [15:10] channel_char
    logic [OUT_W-1:0]     m_axis_tdata;

    // Parser image: the predictor's own copy of the block state.
    logic                 rx_pay_on   = 1'b0;
    logic [LEN_W-1:0]     rx_pay_left = '0;
    logic                 rx_len_on   = 1'b0;
    logic [2:0]           rx_len_pos  = '0;
    logic [2:0]           rx_hdr_pos  = HP_IDLE;

    ipd_result_t          pending_results[$];
    stim_row_t            dir_rows[DIR_N];
    int                   gap_pct      = 0;
    int                   stall_pct    = 0;
    int                   bytes_sent   = 0;
    int                   bytes_taken  = 0;
    int                   results_seen = 0;
    int                   chan_hits    = 0;
    int                   pay_hits     = 0;
    int                   err_count    = 0;

    ipd_frame_payload_extractor u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop: a hung handshake ends the run as a failure.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d results still pending",
                 CYCLE_LIMIT, pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic ipd_result_t payload_of(input logic [7:0] b);
        ipd_result_t r;
        r = '0;
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        return r;
    endfunction

    function automatic ipd_result_t channel_of(input logic [7:0] c);
        ipd_result_t r;
        r = '0;
        r.channel_valid = 1'b1;
        r.channel_char  = c[CH_W-1:0];
        return r;
    endfunction

    // Advance the parser image by one byte and return the result it produces.
    // Stage order matters: payload count, then length gather, then header match.
    function automatic ipd_result_t parse_rx_byte(input logic [7:0] c);
        ipd_result_t r;
        logic [2:0]  hp;
        logic [63:0] wide;
        bit          is_dig;
        r      = '0;
        hp     = rx_hdr_pos;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);

        // Payload count: an exhausted count swallows this byte and closes the frame.
        if (rx_pay_on) begin
            if (rx_pay_left != '0) begin
                rx_pay_left     = rx_pay_left - LEN_W'(1);
                r.payload_valid = 1'b1;
                r.payload_byte  = c;
            end else begin
                rx_pay_on   = 1'b0;
                rx_pay_left = '0;
                rx_len_on   = 1'b0;
            end
        end

        // Length gather: positions past the last counted one only wrap the position.
        if (rx_len_on) begin
            if (rx_len_pos <= DP_LAST_COUNTED) begin
                rx_len_pos = rx_len_pos + 3'd1;
                if (c == CH_COLON) begin
                    rx_len_on  = 1'b0;
                    rx_len_pos = '0;
                    rx_pay_on  = 1'b1;
                end else if (is_dig) begin
                    wide = {{(64-LEN_W){1'b0}}, rx_pay_left} * 64'd10 + 64'(c - CH_ZERO);
                    rx_pay_left = (wide > LEN_CEIL) ? LEN_CEIL[LEN_W-1:0] : wide[LEN_W-1:0];
                end
            end else begin
                rx_len_pos = '0;
            end
        end

        // Header match runs on every byte, payload included.
        if (c == CH_PLUS && hp == HP_IDLE) begin
            hp = HP_PLUS;
        end else if (c == CH_I && hp == HP_PLUS) begin
            hp = HP_I;
        end else if (c == CH_P && hp == HP_I) begin
            hp = HP_P;
        end else if (c == CH_D && hp == HP_P) begin
            hp = HP_D;
        end else if (c == CH_COMMA && hp == HP_D) begin
            hp = HP_COMMA;
        end else if (is_dig && hp == HP_COMMA) begin
            hp = HP_CHAN;
            r  = channel_of(c) | r;
        end else if (c == CH_COMMA && hp == HP_CHAN) begin
            hp          = HP_IDLE;
            rx_len_on   = 1'b1;
            rx_len_pos  = '0;
            rx_pay_left = '0;
        end else if (c == CH_PLUS && hp == HP_PLUS) begin
            hp = HP_PLUS;
        end else begin
            hp = HP_IDLE;
        end
        rx_hdr_pos = hp;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (err_count < 40)
            $display("ERROR result %0d %s: got 0x%0h, expected 0x%0h",
                     results_seen, what, got, want);
        err_count++;
    endtask

    task automatic check_result(input ipd_result_t got, input ipd_result_t want);
        if (got.payload_valid !== want.payload_valid)
            report_mismatch("payload_valid", got.payload_valid, want.payload_valid);
        if (got.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
        if (got.channel_valid !== want.channel_valid)
            report_mismatch("channel_valid", got.channel_valid, want.channel_valid);
        if (got.channel_char !== want.channel_char)
            report_mismatch("channel_char", got.channel_char, want.channel_char);
    endtask

    // Scoreboard: check result transfers first, then predict accepted input transfers.
    always @(posedge aclk) begin : scoreboard
        ipd_result_t got;
        ipd_result_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pending_results.size() == 0) begin
                    report_mismatch("arrived with nothing pending", got, 0);
                end else begin
                    want = pending_results.pop_front();
                    check_result(got, want);
                end
                results_seen++;
                if (got.payload_valid) pay_hits++;
                if (got.channel_valid) chan_hits++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = parse_rx_byte(s_axis_tdata);
                // Directed rows with a typed-in answer override the prediction.
                if (bytes_taken < DIR_N && dir_rows[bytes_taken].pinned)
                    want = dir_rows[bytes_taken].res;
                pending_results.push_back(want);
                bytes_taken++;
            end
        end
    end

    // Result side backpressure, redrawn every cycle.
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Hold tvalid low for random gaps, then present the byte until it is taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // Drop tvalid and hold off until every pending result has been checked.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
        @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    // Payload bytes lean toward header characters so stray matches happen inside frames.
    function automatic logic [7:0] payload_char();
        logic [7:0] picks[7];
        picks = '{CH_PLUS, CH_I, CH_P, CH_D, CH_COMMA, CH_COLON, rand_digit()};
        if ($urandom_range(3) == 0)
            return picks[$urandom_range(6)];
        return 8'($urandom_range(255));
    endfunction

    // Send the first keep bytes of "+IPD,<ch>,".
    task automatic send_header(input int keep, input logic [7:0] ch);
        logic [7:0] hdr[7];
        hdr = '{CH_PLUS, CH_I, CH_P, CH_D, CH_COMMA, ch, CH_COMMA};
        for (int i = 0; i < keep && i < 7; i++) send_byte(hdr[i]);
    endtask

    // One random frame: mostly well formed, the rest odd lengths, broken headers or noise.
    task automatic send_frame();
        int    kind;
        int    len;
        int    n;
        bit    nines;
        string digits;
        kind = $urandom_range(99);
        if (kind >= 90) begin
            n = $urandom_range(8, 1);
            repeat (n) send_byte(8'($urandom_range(255)));
        end else if (kind >= 80) begin
            // cut the header short and follow with junk or an extra '+'
            send_header($urandom_range(6), rand_digit());
            send_byte($urandom_range(1) ? CH_PLUS : 8'($urandom_range(255)));
        end else begin
            send_header(7, rand_digit());
            len = 0;
            if (kind < 60) begin
                len    = ($urandom_range(3) == 0) ? $urandom_range(40, 9) : $urandom_range(8);
                digits = $sformatf("%0d", len);
                foreach (digits[i]) send_byte(digits[i]);
            end else if (kind < 70) begin
                // too many digits: wraps the position and may saturate the count
                n     = $urandom_range(9, 7);
                nines = $urandom_range(1);
                repeat (n) send_byte(nines ? CH_NINE : rand_digit());
            end else begin
                // length digits mixed with junk
                n = $urandom_range(4, 1);
                repeat (n) begin
                    if ($urandom_range(1)) send_byte(rand_digit());
                    else send_byte($urandom_range(1) ? CH_COMMA : 8'h78);
                end
            end
            send_byte(CH_COLON);
            n = (kind < 60) ? len : $urandom_range(6);
            repeat (n) send_byte(payload_char());
            // a header inside a runaway payload clears the count; the next byte closes it
            if (kind >= 60) begin
                send_header(7, CH_ZERO);
                send_byte(8'h7A);
            end
        end
    endtask

    initial begin : stimulus
        int gap_tab[4];
        int stall_tab[4];
        int target;
        gap_tab   = '{0, 72, 0, 35};
        stall_tab = '{0, 0, 72, 35};

        // Directed walk: reset quiet, '+' handling, channel capture, junk in the
        // length, payload extremes and the byte that closes the payload.
        dir_rows = '{
            '{8'h00,    1'b1, QUIET},
            '{8'hFF,    1'b1, QUIET},
            '{CH_PLUS,  1'b0, QUIET},
            '{CH_PLUS,  1'b0, QUIET},   // repeated '+' holds the first position
            '{CH_I,     1'b0, QUIET},
            '{CH_PLUS,  1'b0, QUIET},   // '+' further in drops the match
            '{CH_PLUS,  1'b0, QUIET},
            '{CH_I,     1'b0, QUIET},
            '{CH_P,     1'b0, QUIET},
            '{CH_D,     1'b0, QUIET},
            '{CH_COMMA, 1'b0, QUIET},
            '{CH_NINE,  1'b1, channel_of(CH_NINE)},
            '{CH_COMMA, 1'b0, QUIET},
            '{CH_ZERO,  1'b0, QUIET},
            '{8'h78,    1'b0, QUIET},   // non-digit only advances the position
            '{8'h32,    1'b0, QUIET},
            '{CH_COLON, 1'b0, QUIET},
            '{8'h00,    1'b1, payload_of(8'h00)},
            '{8'hFF,    1'b1, payload_of(8'hFF)},
            '{CH_PLUS,  1'b1, QUIET}    // count exhausted: not payload
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_byte(dir_rows[i].b);
        drain_results();

        // Random frames across four handshake phases; drain between them.
        for (int ph = 0; ph < 4; ph++) begin
            gap_pct   = gap_tab[ph];
            stall_pct = stall_tab[ph];
            target    = bytes_sent + RAND_ITEMS / 4;
            while (bytes_sent < target) send_frame();
            drain_results();
        end

        stall_pct = 0;
        repeat (4) @(posedge aclk);
        $display("Sent %0d bytes (%0d directed) under four stall/gap mixes;", bytes_sent, DIR_N);
        $display("checked %0d results: %0d payload bytes, %0d channel captures.",
                 results_seen, pay_hits, chan_hits);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
